FILE: rtl/nsba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsba_pkg
// Shared types and constants for the nearest-symbol-below-address lookup.
// ----------------------------------------------------------------------------
package nsba_pkg;

    localparam int TABLE_ENTRIES = 4096;

    localparam int INDEX_W = 12;
    localparam int DATA_W  = 32;
    localparam int TYPE_W  = 8;

    // entry position saturates at the smaller of the last table position and the largest index
    localparam int INDEX_CAP_INT = (TABLE_ENTRIES - 1 < (1 << INDEX_W) - 1)
                                   ? TABLE_ENTRIES - 1 : (1 << INDEX_W) - 1;
    localparam logic [INDEX_W-1:0] INDEX_CAP = INDEX_W'(INDEX_CAP_INT);

    localparam logic [TYPE_W-1:0] TYPE_STAB_MASK = 8'hE0;
    localparam logic [TYPE_W-1:0] TYPE_FILE_NAME = 8'h1F;
    localparam int                TYPE_EXT_POS   = 0;

    // depth of the queue between front and back, and of the result buffer
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QCNT_W-1:0] QUEUE_FULL_COUNT = QCNT_W'(QUEUE_DEPTH);
    localparam logic [QPTR_W-1:0] QUEUE_LAST_PTR   = QPTR_W'(QUEUE_DEPTH - 1);

    // classified entry handed from front to back
    typedef struct packed {
        logic               first;
        logic               last;
        logic               eligible;
        logic               external;
        logic [DATA_W-1:0]  delta;
        logic [DATA_W-1:0]  addr;
        logic [DATA_W-1:0]  limit;
        logic [INDEX_W-1:0] idx;
    } entry_t;

    // one lookup result
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] match_index;
        logic [DATA_W-1:0]  distance;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/nsba_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsba_front
// Accepts symbol entries, marks the eligible ones and numbers them within the run.
// ----------------------------------------------------------------------------
module nsba_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              external_only_we,
    input  wire logic                              external_only,
    input  wire logic                              accept,
    input  wire logic                              first_entry,
    input  wire logic                              last_entry,
    input  wire logic [nsba_pkg::DATA_W-1:0]       query_address,
    input  wire logic [nsba_pkg::DATA_W-1:0]       max_distance,
    input  wire logic [nsba_pkg::DATA_W-1:0]       entry_value,
    input  wire logic [nsba_pkg::TYPE_W-1:0]       entry_type,
    input  wire logic                              entry_named,
    output nsba_pkg::entry_t                       item
);

    logic                         ext_only_reg;
    logic [nsba_pkg::INDEX_W-1:0] count_reg;
    logic [nsba_pkg::INDEX_W-1:0] count_next;
    logic [nsba_pkg::INDEX_W-1:0] count_base;
    logic                         is_ext;
    logic                         type_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_only_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            if (external_only_we)
            begin
                ext_only_reg <= external_only;
            end
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_comb
    begin
        count_base = first_entry ? '0 : count_reg;
        count_next = (count_base < nsba_pkg::INDEX_CAP) ? count_base + 1'b1 : count_base;

        is_ext  = entry_type[nsba_pkg::TYPE_EXT_POS];
        // no debug-stab bits and not a file-name marker
        type_ok = ((entry_type & nsba_pkg::TYPE_STAB_MASK) == '0)
                  && (entry_type != nsba_pkg::TYPE_FILE_NAME);

        item.first    = first_entry;
        item.last     = last_entry;
        item.external = is_ext;
        item.eligible = entry_named && type_ok && !(ext_only_reg && !is_ext)
                        && (query_address >= entry_value);
        item.delta    = query_address - entry_value;
        item.addr     = query_address;
        item.limit    = max_distance;
        item.idx      = count_base;
    end

endmodule
`default_nettype wire

FILE: rtl/nsba_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsba_queue
// Short queue of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module nsba_queue (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire nsba_pkg::entry_t wr_item,
    input  wire logic       rd_en,
    output nsba_pkg::entry_t rd_item,
    output logic            full,
    output logic            empty
);

    nsba_pkg::entry_t               mem [nsba_pkg::QUEUE_DEPTH];
    logic [nsba_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [nsba_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [nsba_pkg::QCNT_W-1:0]    count_reg;
    logic [nsba_pkg::QCNT_W-1:0]    count_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == nsba_pkg::QUEUE_LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == nsba_pkg::QUEUE_LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    assign rd_item = mem[rd_ptr_reg];
    assign full    = (count_reg == nsba_pkg::QUEUE_FULL_COUNT);
    assign empty   = (count_reg == '0);

endmodule
`default_nettype wire

FILE: rtl/nsba_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsba_back
// Keeps the running best match and buffers the result of each run.
// ----------------------------------------------------------------------------
module nsba_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire nsba_pkg::entry_t              item,
    input  wire logic                          item_empty,
    output logic                               item_take,
    input  wire logic                          pop,
    output logic                               empty,
    output logic                               found,
    output logic [nsba_pkg::INDEX_W-1:0]       match_index,
    output logic [nsba_pkg::DATA_W-1:0]        distance
);

    logic [nsba_pkg::DATA_W-1:0]  best_dist_reg;
    logic [nsba_pkg::INDEX_W-1:0] best_idx_reg;
    logic                         best_ext_reg;
    logic                         have_best_reg;
    logic                         done_reg;

    logic [nsba_pkg::DATA_W-1:0]  base_dist;
    logic [nsba_pkg::INDEX_W-1:0] base_idx;
    logic                         base_ext;
    logic                         base_have;
    logic                         base_done;

    logic [nsba_pkg::DATA_W-1:0]  best_dist_next;
    logic [nsba_pkg::INDEX_W-1:0] best_idx_next;
    logic                         best_ext_next;
    logic                         have_best_next;
    logic                         done_next;
    logic                         usable;

    nsba_pkg::result_t            res;
    nsba_pkg::result_t            obuf [nsba_pkg::QUEUE_DEPTH];
    logic [nsba_pkg::QPTR_W-1:0]  owr_ptr_reg;
    logic [nsba_pkg::QPTR_W-1:0]  ord_ptr_reg;
    logic [nsba_pkg::QCNT_W-1:0]  ocount_reg;
    logic [nsba_pkg::QCNT_W-1:0]  ocount_next;
    logic                         opush;
    logic                         opop;

    always_comb
    begin
        // first entry of a run starts from the limit with nothing held
        if (item.first)
        begin
            base_dist = item.limit;
            base_idx  = '0;
            base_ext  = 1'b0;
            base_have = 1'b0;
            base_done = 1'b0;
        end
        else
        begin
            base_dist = best_dist_reg;
            base_idx  = best_idx_reg;
            base_ext  = best_ext_reg;
            base_have = have_best_reg;
            base_done = done_reg;
        end

        best_dist_next = base_dist;
        best_idx_next  = base_idx;
        best_ext_next  = base_ext;
        have_best_next = base_have;
        done_next      = base_done;
        usable         = item.eligible && !base_done;

        if (usable)
        begin
            if (item.delta < base_dist)
            begin
                best_dist_next = item.delta;
                best_idx_next  = item.idx;
                best_ext_next  = item.external;
                have_best_next = 1'b1;
                // exact external hit closes the search for this run
                done_next      = (item.delta == '0) && item.external;
            end
            else if ((item.delta == base_dist) && (!base_have || (!base_ext && item.external)))
            begin
                best_dist_next = item.delta;
                best_idx_next  = item.idx;
                best_ext_next  = item.external;
                have_best_next = 1'b1;
            end
        end

        res.found       = have_best_next;
        res.match_index = have_best_next ? best_idx_next : '0;
        res.distance    = have_best_next ? best_dist_next : item.addr;
    end

    // a last entry waits only when the result buffer has no room
    assign item_take = !item_empty && (!item.last || (ocount_reg != nsba_pkg::QUEUE_FULL_COUNT));
    assign opush     = item_take && item.last;
    assign opop      = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_reg <= '0;
            best_idx_reg  <= '0;
            best_ext_reg  <= 1'b0;
            have_best_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else if (item_take)
        begin
            best_dist_reg <= best_dist_next;
            best_idx_reg  <= best_idx_next;
            best_ext_reg  <= best_ext_next;
            have_best_reg <= have_best_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (opush)
        begin
            obuf[owr_ptr_reg] <= res;
        end
    end

    always_comb
    begin
        ocount_next = ocount_reg;
        if (opush && !opop)
        begin
            ocount_next = ocount_reg + 1'b1;
        end
        else if (!opush && opop)
        begin
            ocount_next = ocount_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocount_reg  <= '0;
        end
        else
        begin
            ocount_reg <= ocount_next;
            if (opush)
            begin
                owr_ptr_reg <= (owr_ptr_reg == nsba_pkg::QUEUE_LAST_PTR) ? '0 : owr_ptr_reg + 1'b1;
            end
            if (opop)
            begin
                ord_ptr_reg <= (ord_ptr_reg == nsba_pkg::QUEUE_LAST_PTR) ? '0 : ord_ptr_reg + 1'b1;
            end
        end
    end

    assign empty       = (ocount_reg == '0);
    assign found       = obuf[ord_ptr_reg].found;
    assign match_index = obuf[ord_ptr_reg].match_index;
    assign distance    = obuf[ord_ptr_reg].distance;

endmodule
`default_nettype wire

FILE: rtl/nearest_symbol_below_address_core.sv
`timescale 1ns / 1ps
`default_nettype none
// result path: after its last entry is accepted, a result passes the entry queue and then
// the result buffer to the outputs, when no entry is queued ahead of it
// throughput: one entry per cycle while not full; the best-match update is combinational
// the entry queue and the result buffer are two deep each, so either side may stall alone
// reset: asynchronous, active low; clears both queues, the search state, the entry
// counter and external_only; ready for entries in the first cycle after reset
// ----------------------------------------------------------------------------
// nearest_symbol_below_address_core
// Nearest preceding symbol lookup over a streamed symbol table.
// ----------------------------------------------------------------------------
module nearest_symbol_below_address_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          external_only_we,
    input  wire logic                          external_only,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          first_entry,
    input  wire logic                          last_entry,
    input  wire logic [nsba_pkg::DATA_W-1:0]   query_address,
    input  wire logic [nsba_pkg::DATA_W-1:0]   max_distance,
    input  wire logic [nsba_pkg::DATA_W-1:0]   entry_value,
    input  wire logic [nsba_pkg::TYPE_W-1:0]   entry_type,
    input  wire logic                          entry_named,
    output logic                               empty,
    input  wire logic                          pop,
    output logic                               found,
    output logic [nsba_pkg::INDEX_W-1:0]       match_index,
    output logic [nsba_pkg::DATA_W-1:0]        distance
);

    nsba_pkg::entry_t front_item;
    nsba_pkg::entry_t back_item;
    logic             accept;
    logic             q_empty;
    logic             q_take;

    assign accept = push && !full;

    nsba_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .external_only_we (external_only_we),
        .external_only    (external_only),
        .accept           (accept),
        .first_entry      (first_entry),
        .last_entry       (last_entry),
        .query_address    (query_address),
        .max_distance     (max_distance),
        .entry_value      (entry_value),
        .entry_type       (entry_type),
        .entry_named      (entry_named),
        .item             (front_item)
    );

    nsba_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_item (front_item),
        .rd_en   (q_take),
        .rd_item (back_item),
        .full    (full),
        .empty   (q_empty)
    );

    nsba_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (back_item),
        .item_empty  (q_empty),
        .item_take   (q_take),
        .pop         (pop),
        .empty       (empty),
        .found       (found),
        .match_index (match_index),
        .distance    (distance)
    );

endmodule
`default_nettype wire

FILE: tb/nearest_symbol_below_address_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_symbol_below_address_core_tb
// Streams symbol table runs into the lookup core. Bursty input and a stalling
// result side run throughout, with one long result hold-off. A running model
// of the search predicts every lookup, and each result is compared with it.
// ----------------------------------------------------------------------------
module nearest_symbol_below_address_core_tb;

    import nsba_pkg::*;

    typedef struct packed {
        logic              first;
        logic              last;
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] limit;
        logic [DATA_W-1:0] value;
        logic [TYPE_W-1:0] sym_type;
        logic              named;
    } symbol_entry_t;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASE_ITEMS   = 300;
    localparam int LONG_RUN      = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_ext_only = 1'b0;
    logic push = 1'b0;
    logic full;
    logic first_entry = 1'b0;
    logic last_entry = 1'b0;
    logic [DATA_W-1:0] query_address = '0;
    logic [DATA_W-1:0] max_distance = '0;
    logic [DATA_W-1:0] entry_value = '0;
    logic [TYPE_W-1:0] entry_type = '0;
    logic entry_named = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic found;
    logic [INDEX_W-1:0] match_index;
    logic [DATA_W-1:0] distance;

    nearest_symbol_below_address_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .external_only_we (cfg_we),
        .external_only    (cfg_ext_only),
        .push             (push),
        .full             (full),
        .first_entry      (first_entry),
        .last_entry       (last_entry),
        .query_address    (query_address),
        .max_distance     (max_distance),
        .entry_value      (entry_value),
        .entry_type       (entry_type),
        .entry_named      (entry_named),
        .empty            (empty),
        .pop              (pop),
        .found            (found),
        .match_index      (match_index),
        .distance         (distance)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // search state of the lookup as the core should hold it
    logic              ext_only_mode = 1'b0;
    logic [DATA_W-1:0] best_dist = '0;
    logic [INDEX_W-1:0] best_idx = '0;
    logic              best_ext = 1'b0;
    logic              have_best = 1'b0;
    logic              search_done = 1'b0;
    logic [INDEX_W-1:0] entry_pos = '0;

    symbol_entry_t pending_entries[$];
    result_t       expected_lookups[$];

    symbol_entry_t cur_entry;
    bit offering = 1'b0;
    bit entry_taken = 1'b0;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    logic [15:0] stall_pattern = '1;
    int unsigned stall_phase = 0;
    bit hold_request = 1'b0;
    bit hold_off = 1'b0;
    bit full_under_hold = 1'b0;

    int unsigned mismatches = 0;
    int unsigned entries_accepted = 0;
    int unsigned lookups_checked = 0;
    int unsigned lookups_found = 0;

    function automatic void update_nearest(input symbol_entry_t e);
        logic [DATA_W-1:0] delta;
        logic              ext;
        logic              usable;
        result_t           r;
        if (e.first)
        begin
            best_dist   = e.limit;
            best_idx    = '0;
            best_ext    = 1'b0;
            have_best   = 1'b0;
            search_done = 1'b0;
            entry_pos   = '0;
        end
        ext   = e.sym_type[TYPE_EXT_POS];
        delta = e.addr - e.value;
        usable = !search_done && e.named
            && ((e.sym_type & TYPE_STAB_MASK) == '0)
            && !(ext_only_mode && !ext)
            && (e.addr >= e.value)
            && (e.sym_type != TYPE_FILE_NAME);
        if (usable && ((delta < best_dist)
                || (delta == best_dist && (!have_best || (!best_ext && ext)))))
        begin
            // an exact external hit freezes the search for the rest of the run
            if (delta < best_dist && delta == '0 && ext)
                search_done = 1'b1;
            best_dist = delta;
            best_idx  = entry_pos;
            best_ext  = ext;
            have_best = 1'b1;
        end
        if (entry_pos < INDEX_CAP)
            entry_pos++;
        if (e.last)
        begin
            r.found       = have_best;
            r.match_index = have_best ? best_idx : '0;
            r.distance    = have_best ? best_dist : e.addr;
            expected_lookups.push_back(r);
        end
    endfunction

    function automatic void report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $time, msg);
    endfunction

    // input side: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (entry_taken)
            begin
                entry_taken = 1'b0;
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_entries.size() > 0)
                begin
                    cur_entry = pending_entries.pop_front();
                    offering = 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            push          <= offering;
            first_entry   <= cur_entry.first;
            last_entry    <= cur_entry.last;
            query_address <= cur_entry.addr;
            max_distance  <= cur_entry.limit;
            entry_value   <= cur_entry.value;
            entry_type    <= cur_entry.sym_type;
            entry_named   <= cur_entry.named;
        end
    end

    // result side: a random 16-bit pop pattern, redrawn each time it runs out
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (stall_phase == 0)
            begin
                stall_phase = 16;
                case ($urandom_range(0, 5))
                    0, 1: stall_pattern = '1;
                    2:    stall_pattern = 16'($urandom & $urandom & $urandom);
                    default: stall_pattern = 16'($urandom);
                endcase
            end
            stall_phase--;
            pop <= !hold_off && stall_pattern[stall_phase];
        end
    end

    // one long hold-off of the result side while the sender keeps pushing
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    always @(posedge clk)
    begin
        symbol_entry_t e;
        result_t       exp_r;
        if (rst_n)
        begin
            if (hold_off && full)
                full_under_hold = 1'b1;
            if (push && !full)
            begin
                e.first    = first_entry;
                e.last     = last_entry;
                e.addr     = query_address;
                e.limit    = max_distance;
                e.value    = entry_value;
                e.sym_type = entry_type;
                e.named    = entry_named;
                update_nearest(e);
                entry_taken = 1'b1;
                entries_accepted++;
            end
            if (pop && !empty)
            begin
                lookups_checked++;
                if (expected_lookups.size() == 0)
                    report_mismatch($sformatf("unexpected result found=%0b index=%0d dist=%h",
                                              found, match_index, distance));
                else
                begin
                    exp_r = expected_lookups.pop_front();
                    if (exp_r.found)
                        lookups_found++;
                    if (found !== exp_r.found || match_index !== exp_r.match_index
                            || distance !== exp_r.distance)
                        report_mismatch($sformatf(
                            "expected found=%0b index=%0d dist=%h, got found=%0b index=%0d dist=%h",
                            exp_r.found, exp_r.match_index, exp_r.distance,
                            found, match_index, distance));
                end
            end
        end
    end

    task automatic queue_entry(input logic first, input logic last, input logic [31:0] addr,
                               input logic [31:0] limit, input logic [31:0] value,
                               input logic [7:0] sym_type, input logic named);
        symbol_entry_t e;
        e.first    = first;
        e.last     = last;
        e.addr     = addr;
        e.limit    = limit;
        e.value    = value;
        e.sym_type = sym_type;
        e.named    = named;
        pending_entries.push_back(e);
    endtask

    // one run of entries around one address; broken runs miss or repeat markers and may move it
    task automatic queue_random_run(input int unsigned len, input bit broken);
        logic [31:0] addr;
        logic [31:0] limit;
        logic [31:0] value;
        logic [7:0]  sym_type;
        logic        first;
        logic        last;
        case ($urandom_range(0, 3))
            0:       addr = $urandom_range(0, 20);
            1:       addr = 32'hFFFF_FFFF - $urandom_range(0, 20);
            default: addr = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0, 1: limit = 32'hFFFF_FFFF;
            2:    limit = $urandom;
            3:    limit = $urandom_range(0, 20);
            default: limit = '0;
        endcase
        for (int unsigned i = 0; i < len; i++)
        begin
            first = (i == 0);
            last  = (i == len - 1);
            if (broken)
            begin
                first = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0);
                last  = last || ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 5) == 0)
                    addr = $urandom;
            end
            case ($urandom_range(0, 7))
                0:       value = $urandom;
                1:       value = addr;
                6:       value = addr + $urandom_range(1, 8);
                7:       value = addr - $urandom_range(0, 40);
                default: value = addr - $urandom_range(0, 6);
            endcase
            case ($urandom_range(0, 9))
                0, 1:    sym_type = 8'($urandom);
                2:       sym_type = TYPE_FILE_NAME;
                3:       sym_type = 8'($urandom) | 8'h20;
                default: sym_type = 8'($urandom_range(0, 15));
            endcase
            queue_entry(first, last, addr, limit, value, sym_type, $urandom_range(0, 9) != 0);
        end
    endtask

    task automatic queue_random_phase(input int unsigned items, input bit short_runs);
        int unsigned queued;
        int unsigned len;
        queued = 0;
        while (queued < items)
        begin
            if (short_runs)
                len = $urandom_range(1, 3);
            else
                case ($urandom_range(0, 19))
                    0:          len = $urandom_range(41, 80);
                    1, 2, 3:    len = $urandom_range(9, 40);
                    default:    len = $urandom_range(1, 8);
                endcase
            queue_random_run(len, $urandom_range(0, 9) == 0);
            queued += len;
        end
    endtask

    // wait until everything sent has come back, then let the pipe settle
    task automatic drain_block();
        while (pending_entries.size() != 0 || push || expected_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_ext_only(input logic v);
        @(negedge clk);
        cfg_we       <= 1'b1;
        cfg_ext_only <= v;
        ext_only_mode = v;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // entry with no run start continues from the reset state
        queue_entry(0, 1, 32'h10, 32'h55, 32'h10, 8'h00, 1);
        // skip rules, ties, closer entries and an exact external hit
        queue_entry(1, 0, 32'h1000, 32'h100, 32'hFF0, 8'h00, 0);
        queue_entry(0, 0, 32'h1000, 32'h100, 32'hFFF, 8'h24, 1);
        queue_entry(0, 0, 32'h1000, 32'h100, 32'hFFF, TYPE_FILE_NAME, 1);
        queue_entry(0, 0, 32'h1000, 32'h100, 32'h1001, 8'h01, 1);
        queue_entry(0, 0, 32'h1000, 32'h100, 32'hFF0, 8'h04, 1);
        queue_entry(0, 0, 32'h1000, 32'h100, 32'hFF0, 8'h05, 1);
        queue_entry(0, 0, 32'h1000, 32'h100, 32'hFF0, 8'h04, 1);
        queue_entry(0, 0, 32'h1000, 32'h100, 32'hFFE, 8'h06, 1);
        queue_entry(0, 0, 32'h1000, 32'h100, 32'h1000, 8'h07, 1);
        queue_entry(0, 1, 32'h1000, 32'h100, 32'h1000, 8'h09, 1);
        // entry after the end marker extends the same run
        queue_entry(0, 1, 32'h1000, 32'h0, 32'h1000, 8'h01, 1);
        // address and limit extremes
        queue_entry(1, 1, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'h05, 1);
        queue_entry(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 8'h00, 1);
        queue_entry(1, 1, 32'h0, 32'h0, 32'h0, 8'h01, 1);
        // address moves within a run
        queue_entry(1, 0, 32'h200, 32'h20, 32'h1F0, 8'h02, 1);
        queue_entry(0, 1, 32'h300, 32'h20, 32'h2F8, 8'h03, 1);
        // ties at the limit itself
        queue_entry(1, 0, 32'h500, 32'h5, 32'h4FB, 8'h02, 1);
        queue_entry(0, 0, 32'h500, 32'h5, 32'h4FB, 8'h03, 1);
        queue_entry(0, 1, 32'h500, 32'h5, 32'h4FB, 8'h0E, 1);
        drain_block();

        write_ext_only(1'b1);
        queue_entry(1, 0, 32'h800, 32'h100, 32'h7FF, 8'h04, 1);
        queue_entry(0, 0, 32'h800, 32'h100, 32'h7FD, 8'h05, 1);
        queue_entry(0, 1, 32'h800, 32'h100, 32'h7FC, 8'h00, 1);
        queue_random_phase(PHASE_ITEMS, 1'b0);
        drain_block();

        write_ext_only(1'b0);
        hold_request = 1'b1;
        queue_random_phase(PHASE_ITEMS, 1'b1);
        drain_block();

        // one long run of unnamed filler with three named candidates, one midway and two near its end
        for (int unsigned i = 0; i < LONG_RUN; i++)
        begin
            if (i == 50)
                queue_entry(0, 0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFCE, 8'h04, 1);
            else if (i == LONG_RUN - 3)
                queue_entry(0, 0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 8'h00, 1);
            else if (i == LONG_RUN - 2)
                queue_entry(0, 0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 8'h01, 1);
            else
                queue_entry(i == 0, i == LONG_RUN - 1, 32'h8000_0000, 32'hFFFF_FFFF,
                            $urandom, 8'($urandom), 0);
        end
        drain_block();

        write_ext_only(1'b1);
        queue_random_phase(PHASE_ITEMS, 1'b0);
        drain_block();

        mismatches += expected_lookups.size();
        $display("covered %0d entries, %0d lookups checked (%0d hits), external-only on and off",
                 entries_accepted, lookups_checked, lookups_found);
        $display("long run done, input stalled under result hold-off: %0s",
                 full_under_hold ? "yes" : "no");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", expected_lookups.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/nsba_pkg.sv
rtl/nsba_front.sv
rtl/nsba_queue.sv
rtl/nsba_back.sv
rtl/nearest_symbol_below_address_core.sv
tb/nearest_symbol_below_address_core_tb.sv
